// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Compact wrappers for clocked property checks, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/nns_pkg.sv
// ---------------------------------------------------------------------------
// nns_pkg
// Types, sizes, register indexes and helpers of the nearest neighbor scaler.
// ---------------------------------------------------------------------------
package nns_pkg;

  // Image and store sizes
  localparam int MAX_DIM   = 1024;
  localparam int SRC_DEPTH = 16384;

  localparam int POS_W  = $clog2(MAX_DIM);        // coordinate width
  localparam int DIM_W  = POS_W + 1;              // size register width
  localparam int LIDX_W = 2 * POS_W;              // raster load index
  localparam int PROD_W = 2 * POS_W + 1;          // products, area, address
  localparam int SRC_AW = $clog2(SRC_DEPTH);      // store address width

  // Bit-serial step counts
  localparam int CNT_W = $clog2(DIM_W);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DIM_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(POS_W - 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } nns_in_t;

  typedef struct packed {
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic [7:0]       out_alpha;
    logic [POS_W-1:0] dst_x;
    logic [POS_W-1:0] dst_y;
    logic             frame_last;
  } nns_out_t;

  // Clamp a size register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hdl/nearest_neighbour_scaler.sv
// ---------------------------------------------------------------------------
// nearest_neighbour_scaler
// Nearest neighbor image scaler: loads RGBA source pixels into a store and
// emits the scaled destination frame one pixel per fetch item.
// ---------------------------------------------------------------------------
//  channel | ports                               | handshake
//  --------+-------------------------------------+---------------------------
//  input   | start, busy, in_data                | taken when start & !busy
//  result  | out_strobe, out_data                | one cycle, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_index,    | taken when valid & ready
//          | cfg_data                            |
//
// Busy stays high for a whole item: one shared shift-add multiplier forms the
// area for a load item; for a fetch item it and one restoring divider work
// out column and row in turn, then the multiplier forms the address.
// The fetch result is strobed in the first cycle in which busy is low again.
// rst_n is synchronous; reset clears control state only, the store keeps its
// contents. The receiver cannot stall; configuration is always accepted.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_neighbour_scaler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  nns_pkg::nns_in_t                     in_data,
  output logic                                 out_strobe,
  output nns_pkg::nns_out_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nns_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nns_pkg::DIM_W-1:0]            cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LOAD,
    S_READ,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_AREA,
    PH_X,
    PH_Y,
    PH_ADDR
  } phase_t;

  // Control state
  state_t                        state_r, state_nxt;
  phase_t                        phase_r, phase_nxt;
  logic [nns_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [nns_pkg::LIDX_W-1:0]    load_idx_r, load_idx_nxt;
  logic [nns_pkg::POS_W-1:0]     fcol_r, fcol_nxt;
  logic [nns_pkg::POS_W-1:0]     frow_r, frow_nxt;
  logic [nns_pkg::DIM_W-1:0]     src_w_r, src_w_nxt;
  logic [nns_pkg::DIM_W-1:0]     src_h_r, src_h_nxt;
  logic [nns_pkg::DIM_W-1:0]     dst_w_r, dst_w_nxt;
  logic [nns_pkg::DIM_W-1:0]     dst_h_r, dst_h_nxt;
  logic                          out_strobe_r, out_strobe_nxt;

  // Datapath
  logic [nns_pkg::DIM_W-1:0]     mlt_r, mlt_nxt;
  logic [nns_pkg::PROD_W-1:0]    mcd_r, mcd_nxt;
  logic [nns_pkg::PROD_W-1:0]    acc_r, acc_nxt;
  logic [nns_pkg::DIM_W-1:0]     rem_r, rem_nxt;
  logic [nns_pkg::POS_W-1:0]     quo_r, quo_nxt;
  logic [nns_pkg::DIM_W-1:0]     div_r, div_nxt;
  logic [nns_pkg::POS_W-1:0]     sx_r, sx_nxt;
  logic [nns_pkg::DIM_W-1:0]     sw_r, sw_nxt;
  logic [nns_pkg::DIM_W-1:0]     sh_r, sh_nxt;
  logic [nns_pkg::DIM_W-1:0]     dw_r, dw_nxt;
  logic [nns_pkg::DIM_W-1:0]     dh_r, dh_nxt;
  logic [31:0]                   pix_r, pix_nxt;
  nns_pkg::nns_out_t             out_data_r, out_data_nxt;

  // Source store
  logic [31:0]                   src_mem [nns_pkg::SRC_DEPTH];
  logic [31:0]                   rd_data_r;
  logic                          rd_oob_r;
  logic                          mem_we;
  logic                          mem_re;

  // Step logic
  logic [nns_pkg::DIM_W-1:0]     sw_e, sh_e, dw_e, dh_e;
  logic [nns_pkg::POS_W-1:0]     col_e, row_e;
  logic [nns_pkg::PROD_W-1:0]    acc_step;
  logic [nns_pkg::DIM_W:0]       trial;
  logic [nns_pkg::DIM_W:0]       diff;
  logic                          ge;
  logic [nns_pkg::DIM_W-1:0]     rem_step;
  logic [nns_pkg::POS_W-1:0]     quo_step;
  logic [nns_pkg::LIDX_W-1:0]    ld_idx;
  logic [nns_pkg::PROD_W-1:0]    ld_inc;
  logic [nns_pkg::DIM_W-1:0]     col_inc;
  logic [nns_pkg::DIM_W-1:0]     row_inc;

  // Effective sizes and fetch position
  always_comb begin
    sw_e  = nns_pkg::eff_dim(src_w_r);
    sh_e  = nns_pkg::eff_dim(src_h_r);
    dw_e  = nns_pkg::eff_dim(dst_w_r);
    dh_e  = nns_pkg::eff_dim(dst_h_r);
    col_e = (nns_pkg::DIM_W'(fcol_r) >= dw_e) ? '0 : fcol_r;
    row_e = (nns_pkg::DIM_W'(frow_r) >= dh_e) ? '0 : frow_r;
  end

  // One shift-add step and one restoring division step
  always_comb begin
    acc_step = mlt_r[0] ? (acc_r + mcd_r) : acc_r;
    trial    = {rem_r, quo_r[nns_pkg::POS_W-1]};
    diff     = trial - {1'b0, div_r};
    ge       = (trial >= {1'b0, div_r});
    rem_step = ge ? diff[nns_pkg::DIM_W-1:0] : trial[nns_pkg::DIM_W-1:0];
    quo_step = {quo_r[nns_pkg::POS_W-2:0], ge};
  end

  // Load position: restart at zero when outside the current frame
  always_comb begin
    ld_idx = (nns_pkg::PROD_W'(load_idx_r) >= acc_r) ? '0 : load_idx_r;
    ld_inc = nns_pkg::PROD_W'(ld_idx) + nns_pkg::PROD_W'(1);
  end

  assign col_inc = nns_pkg::DIM_W'(fcol_r) + nns_pkg::DIM_W'(1);
  assign row_inc = nns_pkg::DIM_W'(frow_r) + nns_pkg::DIM_W'(1);

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    load_idx_nxt   = load_idx_r;
    fcol_nxt       = fcol_r;
    frow_nxt       = frow_r;
    out_strobe_nxt = 1'b0;
    mlt_nxt        = mlt_r;
    mcd_nxt        = mcd_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_nxt        = div_r;
    sx_nxt         = sx_r;
    sw_nxt         = sw_r;
    sh_nxt         = sh_r;
    dw_nxt         = dw_r;
    dh_nxt         = dh_r;
    pix_nxt        = pix_r;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // Latch sizes and pixel so the item is immune to later writes
          sw_nxt    = sw_e;
          sh_nxt    = sh_e;
          dw_nxt    = dw_e;
          dh_nxt    = dh_e;
          pix_nxt   = {in_data.in_alpha, in_data.in_blue,
                       in_data.in_green, in_data.in_red};
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_MUL;
          if (in_data.func == nns_pkg::FUNC_LOAD) begin
            phase_nxt = PH_AREA;
            mlt_nxt   = sh_e;
            mcd_nxt   = nns_pkg::PROD_W'(sw_e);
          end else begin
            phase_nxt = PH_X;
            fcol_nxt  = col_e;
            frow_nxt  = row_e;
            mlt_nxt   = nns_pkg::DIM_W'(col_e);
            mcd_nxt   = nns_pkg::PROD_W'(sw_e);
          end
        end
      end

      S_MUL: begin
        // Advance one multiplier bit
        acc_nxt = acc_step;
        mlt_nxt = mlt_r >> 1;
        mcd_nxt = mcd_r << 1;
        cnt_nxt = cnt_r + nns_pkg::CNT_W'(1);
        if (cnt_r == nns_pkg::MUL_LAST) begin
          cnt_nxt = '0;
          unique case (phase_r)
            PH_AREA: begin
              state_nxt = S_LOAD;
            end
            PH_X: begin
              state_nxt = S_DIV;
              rem_nxt   = nns_pkg::DIM_W'(acc_step[2*nns_pkg::POS_W-1:nns_pkg::POS_W]);
              quo_nxt   = acc_step[nns_pkg::POS_W-1:0];
              div_nxt   = dw_r;
            end
            PH_Y: begin
              state_nxt = S_DIV;
              rem_nxt   = nns_pkg::DIM_W'(acc_step[2*nns_pkg::POS_W-1:nns_pkg::POS_W]);
              quo_nxt   = acc_step[nns_pkg::POS_W-1:0];
              div_nxt   = dh_r;
            end
            PH_ADDR: begin
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_DIV: begin
        // Advance one quotient bit
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + nns_pkg::CNT_W'(1);
        if (cnt_r == nns_pkg::DIV_LAST) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_MUL;
          unique case (phase_r)
            PH_X: begin
              sx_nxt    = quo_step;
              phase_nxt = PH_Y;
              mlt_nxt   = nns_pkg::DIM_W'(frow_r);
              mcd_nxt   = nns_pkg::PROD_W'(sh_r);
            end
            PH_Y: begin
              // Address = row * src_width + column
              phase_nxt = PH_ADDR;
              mlt_nxt   = nns_pkg::DIM_W'(quo_step);
              mcd_nxt   = nns_pkg::PROD_W'(sw_r);
              acc_nxt   = nns_pkg::PROD_W'(sx_r);
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_LOAD: begin
        // Store is written by the memory block; wrap at the frame area
        load_idx_nxt = (ld_inc >= acc_r) ? '0 : ld_inc[nns_pkg::LIDX_W-1:0];
        state_nxt    = S_IDLE;
      end

      S_READ: begin
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        out_strobe_nxt          = 1'b1;
        out_data_nxt.out_red    = rd_oob_r ? 8'd0 : rd_data_r[7:0];
        out_data_nxt.out_green  = rd_oob_r ? 8'd0 : rd_data_r[15:8];
        out_data_nxt.out_blue   = rd_oob_r ? 8'd0 : rd_data_r[23:16];
        out_data_nxt.out_alpha  = rd_oob_r ? 8'd0 : rd_data_r[31:24];
        out_data_nxt.dst_x      = fcol_r;
        out_data_nxt.dst_y      = frow_r;
        out_data_nxt.frame_last = (col_inc == dw_r) && (row_inc == dh_r);
        // Advance raster position, wrap at frame end
        if (col_inc >= dw_r) begin
          fcol_nxt = '0;
          frow_nxt = (row_inc >= dh_r) ? '0 : row_inc[nns_pkg::POS_W-1:0];
        end else begin
          fcol_nxt = col_inc[nns_pkg::POS_W-1:0];
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Configuration register writes
  always_comb begin
    src_w_nxt = src_w_r;
    src_h_nxt = src_h_r;
    dst_w_nxt = dst_w_r;
    dst_h_nxt = dst_h_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        nns_pkg::CFG_SRC_WIDTH:  src_w_nxt = cfg_data;
        nns_pkg::CFG_SRC_HEIGHT: src_h_nxt = cfg_data;
        nns_pkg::CFG_DST_WIDTH:  dst_w_nxt = cfg_data;
        nns_pkg::CFG_DST_HEIGHT: dst_h_nxt = cfg_data;
        default: begin
          src_w_nxt = src_w_r;
        end
      endcase
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_AREA;
      cnt_r        <= '0;
      load_idx_r   <= '0;
      fcol_r       <= '0;
      frow_r       <= '0;
      src_w_r      <= nns_pkg::DIM_W'(1);
      src_h_r      <= nns_pkg::DIM_W'(1);
      dst_w_r      <= nns_pkg::DIM_W'(1);
      dst_h_r      <= nns_pkg::DIM_W'(1);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      load_idx_r   <= load_idx_nxt;
      fcol_r       <= fcol_nxt;
      frow_r       <= frow_nxt;
      src_w_r      <= src_w_nxt;
      src_h_r      <= src_h_nxt;
      dst_w_r      <= dst_w_nxt;
      dst_h_r      <= dst_h_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    mlt_r      <= mlt_nxt;
    mcd_r      <= mcd_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_r      <= div_nxt;
    sx_r       <= sx_nxt;
    sw_r       <= sw_nxt;
    sh_r       <= sh_nxt;
    dw_r       <= dw_nxt;
    dh_r       <= dh_nxt;
    pix_r      <= pix_nxt;
    out_data_r <= out_data_nxt;
  end

  // Drop loads that land beyond the store
  assign mem_we = (state_r == S_LOAD) &&
                  (nns_pkg::PROD_W'(ld_idx) < nns_pkg::PROD_W'(nns_pkg::SRC_DEPTH));
  assign mem_re = (state_r == S_READ);

  // Source store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      src_mem[ld_idx[nns_pkg::SRC_AW-1:0]] <= pix_r;
    end
    if (mem_re) begin
      rd_data_r <= src_mem[acc_r[nns_pkg::SRC_AW-1:0]];
      rd_oob_r  <= (acc_r >= nns_pkg::PROD_W'(nns_pkg::SRC_DEPTH));
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;
  assign cfg_ready  = 1'b1;

  // Checks
  `ASSERT_NEXT(a_emit_strobe, clk, rst_n, state_r == S_EMIT, out_strobe_r, "emit without strobe")
  `ASSERT_IMPLIES(a_strobe_idle, clk, rst_n, out_strobe_r, !busy, "strobe while busy")
  `ASSERT_IMPLIES(a_div_rem, clk, rst_n, state_r == S_DIV, rem_r < div_r, "remainder overflow")

endmodule

// File: tb/nns_pixel_checker.sv
// ---------------------------------------------------------------------------
// nns_pixel_checker
// Watches the input, result and register channels of the nearest neighbor
// scaler, keeps its own copy of the source store, load index and fetch
// position, and checks every emitted pixel field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module nns_pixel_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  nns_pkg::nns_in_t              in_data,
  input  logic                          out_strobe,
  input  nns_pkg::nns_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nns_pkg::DIM_W-1:0]     cfg_data,
  output int                            mismatch_cnt,
  output int                            pixels_pending,
  output int                            pixels_checked
);

  // Mirror of the block state
  logic [31:0]               src_pixels [nns_pkg::SRC_DEPTH];
  int unsigned               load_pos;
  int unsigned               fetch_x;
  int unsigned               fetch_y;
  logic [nns_pkg::DIM_W-1:0] src_w_reg;
  logic [nns_pkg::DIM_W-1:0] src_h_reg;
  logic [nns_pkg::DIM_W-1:0] dst_w_reg;
  logic [nns_pkg::DIM_W-1:0] dst_h_reg;
  nns_pkg::nns_out_t         expected_pixels [$];

  // Zero reads as one, anything above the largest image saturates
  function automatic int unsigned clamp_dim(input logic [nns_pkg::DIM_W-1:0] v);
    int unsigned r;
    r = 32'(v);
    if (r == 0) r = 1;
    if (r > nns_pkg::MAX_DIM) r = nns_pkg::MAX_DIM;
    return r;
  endfunction

  // Write one source pixel at the raster load position
  task automatic store_source_pixel(input nns_pkg::nns_in_t d);
    int unsigned area;
    int unsigned pos;
    area = clamp_dim(src_w_reg) * clamp_dim(src_h_reg);
    pos  = (load_pos >= area) ? 0 : load_pos;
    if (pos < nns_pkg::SRC_DEPTH) begin
      src_pixels[pos[nns_pkg::SRC_AW-1:0]] = {d.in_alpha, d.in_blue, d.in_green, d.in_red};
    end
    pos++;
    load_pos = (pos >= area) ? 0 : pos;
  endtask

  // Pick the nearest source pixel for the current destination position
  task automatic scale_next_pixel(output nns_pkg::nns_out_t e);
    int unsigned sw, sh, dw, dh;
    int unsigned col, row, sx, sy, addr;
    logic [31:0] px;
    sw   = clamp_dim(src_w_reg);
    sh   = clamp_dim(src_h_reg);
    dw   = clamp_dim(dst_w_reg);
    dh   = clamp_dim(dst_h_reg);
    col  = (fetch_x >= dw) ? 0 : fetch_x;
    row  = (fetch_y >= dh) ? 0 : fetch_y;
    sx   = (col * sw) / dw;
    sy   = (row * sh) / dh;
    addr = sy * sw + sx;
    px   = (addr < nns_pkg::SRC_DEPTH) ? src_pixels[addr[nns_pkg::SRC_AW-1:0]] : 32'h0;
    e.out_red    = px[7:0];
    e.out_green  = px[15:8];
    e.out_blue   = px[23:16];
    e.out_alpha  = px[31:24];
    e.dst_x      = col[nns_pkg::POS_W-1:0];
    e.dst_y      = row[nns_pkg::POS_W-1:0];
    e.frame_last = (col == dw - 1) && (row == dh - 1);
    // Advance in raster order, wrap after the last pixel
    col++;
    if (col >= dw) begin
      col = 0;
      row++;
      if (row >= dh) row = 0;
    end
    fetch_x = col;
    fetch_y = row;
  endtask

  task automatic cmp_field(input string fname, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    nns_pkg::nns_out_t e;
    if (!rst_n) begin
      load_pos       = 0;
      fetch_x        = 0;
      fetch_y        = 0;
      src_w_reg      = nns_pkg::DIM_W'(1);
      src_h_reg      = nns_pkg::DIM_W'(1);
      dst_w_reg      = nns_pkg::DIM_W'(1);
      dst_h_reg      = nns_pkg::DIM_W'(1);
      mismatch_cnt   = 0;
      pixels_checked = 0;
      expected_pixels.delete();
    end else begin
      // Check an emitted pixel against the oldest expectation
      if (out_strobe) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, got %h", $time, out_data);
          mismatch_cnt++;
        end else begin
          e = expected_pixels.pop_front();
          cmp_field("out_red",    32'(e.out_red),    32'(out_data.out_red));
          cmp_field("out_green",  32'(e.out_green),  32'(out_data.out_green));
          cmp_field("out_blue",   32'(e.out_blue),   32'(out_data.out_blue));
          cmp_field("out_alpha",  32'(e.out_alpha),  32'(out_data.out_alpha));
          cmp_field("dst_x",      32'(e.dst_x),      32'(out_data.dst_x));
          cmp_field("dst_y",      32'(e.dst_y),      32'(out_data.dst_y));
          cmp_field("frame_last", 32'(e.frame_last), 32'(out_data.frame_last));
          pixels_checked++;
        end
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nns_pkg::CFG_SRC_WIDTH:  src_w_reg = cfg_data;
          nns_pkg::CFG_SRC_HEIGHT: src_h_reg = cfg_data;
          nns_pkg::CFG_DST_WIDTH:  dst_w_reg = cfg_data;
          nns_pkg::CFG_DST_HEIGHT: dst_h_reg = cfg_data;
          default: ;
        endcase
      end
      // Apply an accepted item
      if (start && !busy) begin
        if (in_data.func == nns_pkg::FUNC_FETCH) begin
          scale_next_pixel(e);
          expected_pixels.push_back(e);
        end else begin
          store_source_pixel(in_data);
        end
      end
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

// File: tb/tb_nearest_neighbour_scaler.sv
// ---------------------------------------------------------------------------
// tb_nearest_neighbour_scaler
// Preloads the low source entries, runs directed corner items (plain copy,
// size clamping, reads past the store, a shrunk frame) and random frames
// with bursty input; the pixel checker judges every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nearest_neighbour_scaler;

  localparam int RESET_CYCLES = 7;
  localparam int IDLE_WAIT    = 64;          // longer than one fetch item
  localparam int PRE_W        = 16;
  localparam int PRE_H        = 16;          // covers every read of small frames
  localparam int TOTAL_ITEMS  = 1000;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          start     = 1'b0;
  logic                          busy;
  nns_pkg::nns_in_t              in_data   = '0;
  logic                          out_strobe;
  nns_pkg::nns_out_t             out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index = nns_pkg::CFG_SRC_WIDTH;
  logic [nns_pkg::DIM_W-1:0]     cfg_data  = '0;

  int mismatch_cnt;
  int pixels_pending;
  int pixels_checked;
  int cycle_cnt  = 0;
  int burst_left = 0;
  int gap_hi     = 0;
  int n_loads    = 0;
  int n_fetches  = 0;
  int n_cfg      = 0;

  nearest_neighbour_scaler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  nns_pixel_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_strobe     (out_strobe),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_cnt   (mismatch_cnt),
    .pixels_pending (pixels_pending),
    .pixels_checked (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_nearest_neighbour_scaler: FAIL");
      $finish;
    end
  end

  function automatic nns_pkg::nns_in_t make_item(input logic f, input logic [31:0] px);
    nns_pkg::nns_in_t d;
    d.func     = f;
    d.in_red   = px[7:0];
    d.in_green = px[15:8];
    d.in_blue  = px[23:16];
    d.in_alpha = px[31:24];
    return d;
  endfunction

  // Half the time small sizes, otherwise zero, one, the maximum or past it
  function automatic int unsigned pick_dim();
    int unsigned v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 1;
      2:       v = nns_pkg::MAX_DIM;
      3:       v = $urandom_range(nns_pkg::MAX_DIM + 1, (1 << nns_pkg::DIM_W) - 1);
      default: v = $urandom_range(1, 16);
    endcase
    return v;
  endfunction

  // Small source sizes only, so every read lands on a preloaded entry
  function automatic int unsigned pick_src_dim();
    int unsigned v;
    case ($urandom_range(0, 3))
      0:       v = 0;
      1:       v = 1;
      default: v = $urandom_range(1, PRE_W);
    endcase
    return v;
  endfunction

  // Send one item; open a new burst after a random gap when one runs out
  task automatic send(input nns_pkg::nns_in_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = (gap_hi == 0) ? 0 : $urandom_range(0, gap_hi);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (d.func == nns_pkg::FUNC_LOAD) n_loads++;
    else n_fetches++;
  endtask

  // Hold off until every pixel has come and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    while (pixels_pending != 0 || busy) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [nns_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= nns_pkg::DIM_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    n_cfg++;
  endtask

  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned dw, input int unsigned dh);
    settle();
    write_reg(nns_pkg::CFG_SRC_WIDTH, sw);
    write_reg(nns_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(nns_pkg::CFG_DST_WIDTH, dw);
    write_reg(nns_pkg::CFG_DST_HEIGHT, dh);
  endtask

  initial begin
    int unsigned sw, sh, dw, dh;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Preload the low store entries, then read back row zero as a plain copy
    set_sizes(PRE_W, PRE_H, PRE_W, PRE_H);
    for (int k = 0; k < PRE_W * PRE_H; k++) send(make_item(nns_pkg::FUNC_LOAD, $urandom));
    for (int k = 0; k < PRE_W; k++) send(make_item(nns_pkg::FUNC_FETCH, $urandom));

    // Equal-size copy with extreme pixel values, load wrap and frame wrap
    gap_hi = 4;
    set_sizes(2, 2, 2, 2);
    send(make_item(nns_pkg::FUNC_LOAD, 32'h0000_0000));
    send(make_item(nns_pkg::FUNC_LOAD, 32'hFFFF_FFFF));
    send(make_item(nns_pkg::FUNC_LOAD, 32'hA5A5_5A5A));
    send(make_item(nns_pkg::FUNC_LOAD, 32'h5A5A_A5A5));
    repeat (5) send(make_item(nns_pkg::FUNC_FETCH, $urandom));

    // Saturated source width, zero destination width, read past the store
    set_sizes(1100, nns_pkg::MAX_DIM, 0, 2);
    repeat (2) send(make_item(nns_pkg::FUNC_FETCH, $urandom));

    // Zero source width, largest 11-bit source height
    set_sizes(0, (1 << nns_pkg::DIM_W) - 1, 1, 1);
    send(make_item(nns_pkg::FUNC_FETCH, $urandom));

    // Shrink the source frame under a live load position
    set_sizes(3, 1, 1, 2);
    repeat (2) send(make_item(nns_pkg::FUNC_LOAD, $urandom));
    set_sizes(1, 2, 1, 2);
    send(make_item(nns_pkg::FUNC_LOAD, $urandom));
    repeat (2) send(make_item(nns_pkg::FUNC_FETCH, $urandom));

    // Loads under saturated source sizes, then a read of entry zero
    set_sizes((1 << nns_pkg::DIM_W) - 1, 1100, 1, 1);
    repeat (2) send(make_item(nns_pkg::FUNC_LOAD, $urandom));
    send(make_item(nns_pkg::FUNC_FETCH, $urandom));

    // Random phases: mostly whole frames, some noise with extreme sizes
    while (n_loads + n_fetches < TOTAL_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       gap_hi = 0;
        1:       gap_hi = 4;
        2:       gap_hi = 24;
        default: gap_hi = 70;
      endcase
      if ($urandom_range(0, 3) != 0) begin
        sw = $urandom_range(1, 8);
        sh = $urandom_range(1, 8);
        dw = $urandom_range(1, 8);
        dh = $urandom_range(1, 8);
        set_sizes(sw, sh, dw, dh);
        repeat (sw * sh) send(make_item(nns_pkg::FUNC_LOAD, $urandom));
        repeat ($urandom_range(1, dw * dh + dw)) begin
          send(make_item(nns_pkg::FUNC_FETCH, $urandom));
        end
      end else begin
        set_sizes(pick_src_dim(), pick_src_dim(), pick_dim(), pick_dim());
        repeat ($urandom_range(8, 40)) begin
          send(make_item(1'($urandom_range(0, 1)), $urandom));
        end
      end
    end

    // Drain and give the verdict
    settle();
    $display("Sent %0d loads and %0d fetches, %0d register writes; %0d pixels compared.",
             n_loads, n_fetches, n_cfg, pixels_checked);
    $display("Covered size clamping, load and frame wrap, out-of-frame positions, far reads.");
    if (mismatch_cnt == 0 && pixels_pending == 0) begin
      $display("tb_nearest_neighbour_scaler: PASS");
    end else begin
      $display("tb_nearest_neighbour_scaler: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/nns_pkg.sv
hdl/nearest_neighbour_scaler.sv
tb/nns_pixel_checker.sv
tb/tb_nearest_neighbour_scaler.sv
